// ===== design/nmea_sv_pkg.sv =====
// Package for the NMEA sentence validator: phase, talker and kind codes,
// character constants, the sentence-type name table and the hex decoder.
// Depends on nothing.
package nmea_sv_pkg;

  localparam int unsigned MAX_SENTENCE_LEN_DEF = 82;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned HDR_LEN = 5;
  localparam int unsigned KIND_COUNT = 7;

  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_STAR = 8'd42;
  localparam logic [7:0] CH_G = "G";
  localparam logic [7:0] CH_P = "P";
  localparam logic [7:0] CH_N = "N";

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_BODY   = 2'd1,
    PH_HEX_HI = 2'd2,
    PH_HEX_LO = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    TALK_GP    = 2'd0,
    TALK_GN    = 2'd1,
    TALK_OTHER = 2'd2
  } talker_t;

  typedef enum logic [2:0] {
    KIND_RMC  = 3'd0,
    KIND_VTG  = 3'd1,
    KIND_TXT  = 3'd2,
    KIND_GGA  = 3'd3,
    KIND_GSA  = 3'd4,
    KIND_GSV  = 3'd5,
    KIND_GLL  = 3'd6,
    KIND_NONE = 3'd7
  } kind_t;

  localparam logic [23:0] KIND_NAMES [KIND_COUNT] = '{
    "RMC", "VTG", "TXT", "GGA", "GSA", "GSV", "GLL"
  };

  typedef struct packed {
    talker_t talker;
    kind_t   kind;
  } header_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.bad = 1'b0;
    h.val = 4'd0;
    if (c >= "0" && c <= "9") begin
      h.val = 4'(c - "0");
    end else if (c >= "A" && c <= "F") begin
      h.val = 4'(c - "A" + 8'd10);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

// ===== design/nmea_sv_decode.sv =====
// Header decoder: maps the five stored header characters to talker and kind.
// Depends on nmea_sv_pkg.
module nmea_sv_decode (
  input  logic [7:0]           hdr [nmea_sv_pkg::HDR_LEN],
  output nmea_sv_pkg::header_t id
);

  always_comb begin
    id.talker = nmea_sv_pkg::TALK_OTHER;
    if (hdr[0] == nmea_sv_pkg::CH_G && hdr[1] == nmea_sv_pkg::CH_P) begin
      id.talker = nmea_sv_pkg::TALK_GP;
    end else if (hdr[0] == nmea_sv_pkg::CH_G && hdr[1] == nmea_sv_pkg::CH_N) begin
      id.talker = nmea_sv_pkg::TALK_GN;
    end
    id.kind = nmea_sv_pkg::KIND_NONE;
    for (int k = nmea_sv_pkg::KIND_COUNT - 1; k >= 0; k--) begin
      if ({hdr[2], hdr[3], hdr[4]} == nmea_sv_pkg::KIND_NAMES[k]) begin
        id.kind = nmea_sv_pkg::kind_t'(3'(k));
      end
    end
  end

endmodule

// ===== design/nmea_sentence_validator_core.sv =====
// NMEA sentence validator top level: input register, frame state, result register.
// Depends on nmea_sv_pkg and nmea_sv_decode.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   input   | in_valid, in_stall | char_in
//   result  | out_valid, out_stall | talker_code, sentence_kind, sum_computed,
//           |                    | sum_received, sum_ok, hex_bad
//
// One character per cycle while in_stall is low; a result is registered from the
// input register into the result register. The frame state updates from the input
// register. rst clears phase, counters and valid flags. in_stall rises only when
// a closing character waits behind a result beat that is stalled.
module nmea_sentence_validator_core #(
  parameter int unsigned MAX_SENTENCE_LEN = nmea_sv_pkg::MAX_SENTENCE_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] talker_code,
  output logic [2:0] sentence_kind,
  output logic [7:0] sum_computed,
  output logic [7:0] sum_received,
  output logic       sum_ok,
  output logic       hex_bad
);

  localparam int unsigned CW = nmea_sv_pkg::CNT_W;

  logic                     c_valid;
  logic [7:0]               c_char;
  nmea_sv_pkg::phase_t      phase, phase_next;
  logic [7:0]               run_xor, run_xor_next;
  logic [7:0]               hdr [nmea_sv_pkg::HDR_LEN];
  logic [7:0]               hdr_next [nmea_sv_pkg::HDR_LEN];
  logic [CW-1:0]            cnt, cnt_next;
  logic [3:0]               hi_nib, hi_nib_next;
  logic                     hex_err, hex_err_next;

  logic [CW:0]              next_count;
  logic                     overlong;
  nmea_sv_pkg::hex_t        hx;
  logic                     produce;
  logic                     bad;
  logic [7:0]               received;
  logic                     advance;
  nmea_sv_pkg::header_t     id;

  nmea_sv_decode u_decode (
    .hdr (hdr),
    .id  (id)
  );

  assign next_count = {1'b0, cnt} + (CW+1)'(1);
  assign overlong   = next_count > (CW+1)'(MAX_SENTENCE_LEN);
  assign hx         = nmea_sv_pkg::hex_decode(c_char);
  assign bad        = hex_err | hx.bad;
  assign received   = {hi_nib, hx.val};

  always_comb begin
    phase_next   = phase;
    run_xor_next = run_xor;
    hdr_next     = hdr;
    cnt_next     = cnt;
    hi_nib_next  = hi_nib;
    hex_err_next = hex_err;
    produce      = 1'b0;
    if (c_valid) begin
      if (c_char == nmea_sv_pkg::CH_DOLLAR) begin
        phase_next   = nmea_sv_pkg::PH_BODY;
        run_xor_next = 8'd0;
        for (int i = 0; i < nmea_sv_pkg::HDR_LEN; i++) begin
          hdr_next[i] = 8'd0;
        end
        cnt_next     = CW'(1);
        hi_nib_next  = 4'd0;
        hex_err_next = 1'b0;
      end else if (phase != nmea_sv_pkg::PH_IDLE) begin
        if (overlong) begin
          phase_next = nmea_sv_pkg::PH_IDLE;
        end else begin
          cnt_next = next_count[CW-1:0];
          unique case (phase)
            nmea_sv_pkg::PH_BODY: begin
              if (c_char == nmea_sv_pkg::CH_STAR) begin
                phase_next = nmea_sv_pkg::PH_HEX_HI;
              end else begin
                run_xor_next = run_xor ^ c_char;
                if (cnt <= CW'(nmea_sv_pkg::HDR_LEN)) begin
                  hdr_next[cnt[2:0] - 3'd1] = c_char;
                end
              end
            end
            nmea_sv_pkg::PH_HEX_HI: begin
              hi_nib_next  = hx.val;
              hex_err_next = hx.bad;
              phase_next   = nmea_sv_pkg::PH_HEX_LO;
            end
            nmea_sv_pkg::PH_HEX_LO: begin
              hex_err_next = bad;
              produce      = 1'b1;
              phase_next   = nmea_sv_pkg::PH_IDLE;
            end
            default: begin
              phase_next = nmea_sv_pkg::PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  assign advance  = !c_valid || !produce || !out_valid || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= nmea_sv_pkg::PH_IDLE;
      run_xor <= 8'd0;
      for (int i = 0; i < nmea_sv_pkg::HDR_LEN; i++) begin
        hdr[i] <= 8'd0;
      end
      cnt     <= '0;
      hi_nib  <= 4'd0;
      hex_err <= 1'b0;
      c_valid <= 1'b0;
    end else if (advance) begin
      phase   <= phase_next;
      run_xor <= run_xor_next;
      hdr     <= hdr_next;
      cnt     <= cnt_next;
      hi_nib  <= hi_nib_next;
      hex_err <= hex_err_next;
      c_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_char <= char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produce) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      talker_code   <= id.talker;
      sentence_kind <= id.kind;
      sum_computed  <= run_xor;
      sum_received  <= received;
      sum_ok        <= !bad && (received == run_xor);
      hex_bad       <= bad;
    end
  end

endmodule

// ===== design/nmea_sv_checker.sv =====
// Port-level checker for the NMEA sentence validator, bound to the top level.
// Depends on nmea_sv_pkg and nmea_sentence_validator_core.
module nmea_sv_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] talker_code,
  input logic [7:0] sum_computed,
  input logic [7:0] sum_received,
  input logic       sum_ok,
  input logic       hex_bad
);

  a_beat_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({sum_computed, sum_received, sum_ok}))
    else $error("stalled result beat changed");

  a_ok_not_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(sum_ok && hex_bad))
    else $error("sum_ok with bad hex");

  a_ok_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && sum_ok |-> sum_computed == sum_received)
    else $error("sum_ok with differing sums");

  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hex_bad && sum_computed == sum_received |-> sum_ok)
    else $error("matching sums without sum_ok");

  a_talker: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> talker_code != 2'(nmea_sv_pkg::TALK_OTHER + 2'd1))
    else $error("talker code out of range");

endmodule

bind nmea_sentence_validator_core nmea_sv_checker u_nmea_sv_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .talker_code  (talker_code),
  .sum_computed (sum_computed),
  .sum_received (sum_received),
  .sum_ok       (sum_ok),
  .hex_bad      (hex_bad)
);

// ===== tb/nmea_sentence_validator_core_test.sv =====
`timescale 1ns / 100ps

// Testbench for nmea_sentence_validator_core: drives character beats with random gaps
// and result stalls, and checks every result beat against a checksum frame predictor.
// Depends on nmea_sv_pkg and the core RTL; reads no files.

typedef struct {
  nmea_sv_pkg::talker_t talker;
  nmea_sv_pkg::kind_t   kind;
  logic [7:0]           computed;
  logic [7:0]           received;
  logic                 ok;
  logic                 bad;
} frame_result_t;

class frame_checker;
  int unsigned         max_len;
  nmea_sv_pkg::phase_t phase;
  logic [7:0]          run_sum;
  logic [7:0]          hdr [nmea_sv_pkg::HDR_LEN];
  int unsigned         count;
  logic [3:0]          hi_nib;
  logic                hi_bad;
  frame_result_t       results_q[$];
  int unsigned         fail_count;

  function new(int unsigned len);
    max_len = len;
    fail_count = 0;
    phase = nmea_sv_pkg::PH_IDLE;
    run_sum = 8'd0;
    count = 0;
    hi_nib = 4'd0;
    hi_bad = 1'b0;
    foreach (hdr[i]) hdr[i] = 8'd0;
  endfunction

  // {bad, value}
  function logic [4:0] nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c[3:0] + 4'd9)};
    return 5'b10000;
  endfunction

  function nmea_sv_pkg::talker_t talker_of();
    if (hdr[0] == nmea_sv_pkg::CH_G && hdr[1] == nmea_sv_pkg::CH_P)
      return nmea_sv_pkg::TALK_GP;
    if (hdr[0] == nmea_sv_pkg::CH_G && hdr[1] == nmea_sv_pkg::CH_N)
      return nmea_sv_pkg::TALK_GN;
    return nmea_sv_pkg::TALK_OTHER;
  endfunction

  function nmea_sv_pkg::kind_t kind_of();
    for (int k = 0; k < nmea_sv_pkg::KIND_COUNT; k++) begin
      if ({hdr[2], hdr[3], hdr[4]} == nmea_sv_pkg::KIND_NAMES[k])
        return nmea_sv_pkg::kind_t'(k);
    end
    return nmea_sv_pkg::KIND_NONE;
  endfunction

  function void note_char(logic [7:0] c);
    int unsigned   next_count;
    logic [4:0]    lo;
    frame_result_t r;
    if (c == nmea_sv_pkg::CH_DOLLAR) begin
      phase = nmea_sv_pkg::PH_BODY;
      run_sum = 8'd0;
      foreach (hdr[i]) hdr[i] = 8'd0;
      count = 1;
      hi_nib = 4'd0;
      hi_bad = 1'b0;
      return;
    end
    if (phase == nmea_sv_pkg::PH_IDLE) return;
    next_count = count + 1;
    if (next_count > max_len) begin
      phase = nmea_sv_pkg::PH_IDLE;
      return;
    end
    count = next_count;
    case (phase)
      nmea_sv_pkg::PH_BODY: begin
        if (c == nmea_sv_pkg::CH_STAR) begin
          phase = nmea_sv_pkg::PH_HEX_HI;
        end else begin
          run_sum ^= c;
          if (next_count - 2 < nmea_sv_pkg::HDR_LEN) hdr[next_count - 2] = c;
        end
      end
      nmea_sv_pkg::PH_HEX_HI: begin
        {hi_bad, hi_nib} = nibble(c);
        phase = nmea_sv_pkg::PH_HEX_LO;
      end
      default: begin
        lo = nibble(c);
        r.talker = talker_of();
        r.kind = kind_of();
        r.computed = run_sum;
        r.received = {hi_nib, lo[3:0]};
        r.bad = hi_bad | lo[4];
        r.ok = !r.bad && (r.received == run_sum);
        hi_bad = r.bad;
        results_q.push_back(r);
        phase = nmea_sv_pkg::PH_IDLE;
      end
    endcase
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %02h actual %02h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function void check_result(frame_result_t got);
    frame_result_t want;
    if (results_q.size() == 0) begin
      $display("%0t: result beat with no frame pending, sum_computed %02h",
               $time, got.computed);
      fail_count++;
      return;
    end
    want = results_q.pop_front();
    compare_field("talker_code", want.talker, got.talker);
    compare_field("sentence_kind", want.kind, got.kind);
    compare_field("sum_computed", want.computed, got.computed);
    compare_field("sum_received", want.received, got.received);
    compare_field("sum_ok", want.ok, got.ok);
    compare_field("hex_bad", want.bad, got.bad);
  endfunction

  function int unsigned pending();
    return results_q.size();
  endfunction
endclass

module nmea_sentence_validator_core_test;
  localparam int unsigned MAX_LEN = nmea_sv_pkg::MAX_SENTENCE_LEN_DEF;
  localparam int unsigned ITEM_TARGET = 1150;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_in = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] talker_code;
  logic [2:0] sentence_kind;
  logic [7:0] sum_computed;
  logic [7:0] sum_received;
  logic       sum_ok;
  logic       hex_bad;

  frame_checker  sb;
  frame_result_t beat_seen;
  logic [7:0]    frame_q[$];
  bit            burst = 1'b0;
  bit            held = 1'b0;
  bit            paused = 1'b0;
  int unsigned   n_results = 0;
  int unsigned   sentence_items = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nmea_sentence_validator_core #(
    .MAX_SENTENCE_LEN(MAX_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_in(char_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .talker_code(talker_code),
    .sentence_kind(sentence_kind),
    .sum_computed(sum_computed),
    .sum_received(sum_received),
    .sum_ok(sum_ok),
    .hex_bad(hex_bad)
  );

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      beat_seen.talker = nmea_sv_pkg::talker_t'(talker_code);
      beat_seen.kind = nmea_sv_pkg::kind_t'(sentence_kind);
      beat_seen.computed = sum_computed;
      beat_seen.received = sum_received;
      beat_seen.ok = sum_ok;
      beat_seen.bad = hex_bad;
      sb.check_result(beat_seen);
      n_results++;
    end
  end

  // Result side: random stall stretches, one long hold-off early in the random part.
  initial begin
    int unsigned pct;
    int unsigned span;
    wait (!rst);
    forever begin
      if (!held && n_results >= 8) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        held = 1'b1;
      end else begin
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 20;
          2: pct = 50;
          default: pct = 85;
        endcase
        span = $urandom_range(10, 150);
        repeat (span) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [7:0] body_byte(bit wide);
    logic [7:0] c;
    do begin
      c = wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
    end while (c == nmea_sv_pkg::CH_DOLLAR || c == nmea_sv_pkg::CH_STAR);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return 8'("0" + 8'(n));
    return 8'((lower ? "a" : "A") + 8'(n) - 8'd10);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endfunction

  function automatic void add_sum(logic [7:0] v, bit lower);
    frame_q.push_back(hex_char(v[7:4], lower));
    frame_q.push_back(hex_char(v[3:0], lower));
  endfunction

  function automatic void build_noise();
    frame_q.delete();
    repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_sentence();
    logic [7:0]  body[$];
    logic [7:0]  sum;
    int unsigned r;
    int unsigned k;
    int unsigned payload;
    bit          wide;
    frame_q.delete();
    r = $urandom_range(0, 99);
    wide = ($urandom_range(0, 3) == 0);
    if (r < 10) begin
      repeat ($urandom_range(0, 4)) body.push_back(body_byte(wide));
    end else begin
      k = $urandom_range(0, 9);
      if (k < 4) begin
        body.push_back(nmea_sv_pkg::CH_G);
        body.push_back(nmea_sv_pkg::CH_P);
      end else if (k < 8) begin
        body.push_back(nmea_sv_pkg::CH_G);
        body.push_back(nmea_sv_pkg::CH_N);
      end else begin
        repeat (2) body.push_back(body_byte(wide));
      end
      k = $urandom_range(0, 8);
      if (k < nmea_sv_pkg::KIND_COUNT) begin
        body.push_back(nmea_sv_pkg::KIND_NAMES[k][23:16]);
        body.push_back(nmea_sv_pkg::KIND_NAMES[k][15:8]);
        body.push_back(nmea_sv_pkg::KIND_NAMES[k][7:0]);
      end else begin
        repeat (3) body.push_back(body_byte(wide));
      end
      // straddle the length limit now and then
      payload = (r >= 95) ? $urandom_range(71, 75) : $urandom_range(0, 16);
      repeat (payload) body.push_back(body_byte(wide));
    end
    sum = 8'd0;
    foreach (body[i]) sum ^= body[i];
    frame_q.push_back(nmea_sv_pkg::CH_DOLLAR);
    foreach (body[i]) frame_q.push_back(body[i]);
    frame_q.push_back(nmea_sv_pkg::CH_STAR);
    r = $urandom_range(0, 99);
    if (r < 75) begin
      add_sum(sum, 1'b0);
    end else if (r < 85) begin
      add_sum(sum ^ 8'($urandom_range(1, 255)), 1'b0);
    end else if (r < 93) begin
      add_sum(sum, 1'b1);
    end else begin
      frame_q.push_back(body_byte(1'b1));
      frame_q.push_back(body_byte(1'b1));
    end
    // cut the frame short; the next dollar restarts
    if ($urandom_range(0, 99) < 8) begin
      frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 2)];
    end
  endfunction

  task automatic send_char(input logic [7:0] c);
    int unsigned r;
    int unsigned gap;
    in_valid <= 1'b1;
    char_in <= c;
    do @(posedge clk); while (in_stall);
    sb.note_char(c);
    r = $urandom_range(0, 99);
    if (burst || r < 60) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_char(frame_q[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    sb = new(MAX_LEN);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle bytes, a full GN GLL frame, a restart, lowercase hex, a short body with 0xFF
    frame_q = {8'h00, 8'hFF};
    add_text("$GNGLL*");
    add_sum(8'("G" ^ "N" ^ "G" ^ "L" ^ "L"), 1'b0);
    add_text("$$*0a$GP");
    frame_q.push_back(8'hFF);
    add_text("*FF");
    send_frame();
    drain();

    while (sentence_items < ITEM_TARGET) begin
      burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        build_noise();
      end else begin
        build_sentence();
        sentence_items += frame_q.size();
      end
      send_frame();
      if (!paused && sentence_items >= ITEM_TARGET / 2) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
